// File: sv/gsce_pkg.sv
// Shared types and constants of the capture-strategy cost estimator.
// Used by every module of the block; depends on nothing else.
package gsce_pkg;

    localparam int AREA_W   = 27;
    localparam int NFRAG_W  = 16;
    localparam int TIME_W   = 40;
    localparam int SAMPLE_W = 48;
    localparam int LIMIT_W  = 8;
    localparam int TICK_W   = 32;

    // multiply-divide unit widths
    localparam int X_W     = 64;   // signed operand as presented
    localparam int MAG_W   = 62;   // magnitude of any operand seen in practice
    localparam int B_W     = 27;   // multiplier
    localparam int D_W     = 27;   // divisor
    localparam int P_W     = MAG_W + B_W;   // exact product
    localparam int RES_W   = 62;   // signed, saturated to +-2^60
    localparam int MDCNT_W = 7;
    localparam int CAP_BIT = 60;

    localparam logic [1:0] OP_DECIDE = 2'd0;
    localparam logic [1:0] OP_WHOLE  = 2'd1;
    localparam logic [1:0] OP_FRAG   = 2'd2;
    localparam logic [1:0] OP_TICK   = 2'd3;

    localparam logic [1:0] CHOICE_NONE   = 2'd0;
    localparam logic [1:0] CHOICE_BOUNDS = 2'd1;
    localparam logic [1:0] CHOICE_FRAGS  = 2'd2;

    localparam logic [1:0] REG_RATIO  = 2'd0;
    localparam logic [1:0] REG_THRESH = 2'd1;
    localparam logic [1:0] REG_REFR   = 2'd2;

    localparam logic [LIMIT_W-1:0] RATIO_RST  = 8'd9;
    localparam logic [NFRAG_W-1:0] THRESH_RST = 16'd10;
    localparam logic [TICK_W-1:0]  REFR_RST   = 32'd1800000;

    // datapath actions
    localparam logic [4:0] ACT_NONE      = 5'd0;
    localparam logic [4:0] ACT_LOAD      = 5'd1;
    localparam logic [4:0] ACT_TICK      = 5'd2;
    localparam logic [4:0] ACT_SCREEN    = 5'd3;
    localparam logic [4:0] ACT_REFRESH   = 5'd4;
    localparam logic [4:0] ACT_SAVE_A    = 5'd5;
    localparam logic [4:0] ACT_SAVE_G    = 5'd6;
    localparam logic [4:0] ACT_SAVE_TB   = 5'd7;
    localparam logic [4:0] ACT_SAVE_T1   = 5'd8;
    localparam logic [4:0] ACT_SAVE_TF   = 5'd9;
    localparam logic [4:0] ACT_SAVE_NUM  = 5'd10;
    localparam logic [4:0] ACT_DROP_W    = 5'd11;
    localparam logic [4:0] ACT_ADD_W     = 5'd12;
    localparam logic [4:0] ACT_DROP_O    = 5'd13;
    localparam logic [4:0] ACT_ADD_O     = 5'd14;
    localparam logic [4:0] ACT_OUT_MODEL = 5'd15;
    localparam logic [4:0] ACT_OUT_HEUR  = 5'd16;
    localparam logic [4:0] ACT_OUT_EMPTY = 5'd17;

    // operand selections of the multiply-divide unit
    localparam logic [2:0] MD_WSAMP = 3'd0;  // t*256 * S / bounds
    localparam logic [2:0] MD_AVG_W = 3'd1;  // whole sum / whole count
    localparam logic [2:0] MD_AVG_O = 3'd2;  // overhead sum / overhead count
    localparam logic [2:0] MD_AF    = 3'd3;  // A * frag / S
    localparam logic [2:0] MD_AB    = 3'd4;  // A * bounds / S
    localparam logic [2:0] MD_GN    = 3'd5;  // G * n
    localparam logic [2:0] MD_NUMN  = 3'd6;  // num / n

    typedef struct packed {
        logic [1:0]         op;
        logic [AREA_W-1:0]  screen_area;
        logic [AREA_W-1:0]  bounds_area;
        logic [AREA_W-1:0]  frag_area;
        logic [NFRAG_W-1:0] frag_count;
        logic [TIME_W-1:0]  grab_time;
        logic               time_valid;
    } req_t;

    typedef struct packed {
        logic [1:0] choice;
        logic       used_model;
    } rsp_t;

    typedef struct packed {
        logic [LIMIT_W-1:0] ratio_limit;
        logic [NFRAG_W-1:0] frag_threshold;
        logic [TICK_W-1:0]  refresh_ticks;
    } cfg_t;

    typedef struct packed {
        logic [4:0] act;
        logic       md_start;
        logic [2:0] md_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       rep_w_ok;
        logic       rep_o_ok;
        logic       empty_req;
        logic       refresh_due;
        logic       model_ready;
        logic       whole_full;
        logic       over_full;
        logic       md_done;
        logic       out_full;
    } dp_stat_t;

endpackage

// File: sv/grab_strategy_cost_estimator_core.sv
// Capture-strategy cost estimator: one word at a time, taken only once the controller
// is back in idle after the last one. The single shared multiply-divide unit computes
// each product-quotient in 27 shift-add steps, 89 restoring divide steps, one to
// saturate and one to flag done; a model decision makes five such runs, a taken
// fragment report three and a taken single-rectangle report one. A decision waits
// while its result register is still full.
// Configuration is an APB-style port at byte addresses 0, 4 and 8.
// Depends on gsce_pkg and the gsce_* modules.
module grab_strategy_cost_estimator_core #(
    parameter int WINDOW_MAX  = 16,
    parameter int MIN_SAMPLES = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  gsce_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output gsce_pkg::rsp_t  rsp,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [3:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);
    gsce_pkg::cfg_t     cfg_reg;
    gsce_pkg::dp_cmd_t  cmd;
    gsce_pkg::dp_stat_t stat;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ratio_limit    <= gsce_pkg::RATIO_RST;
            cfg_reg.frag_threshold <= gsce_pkg::THRESH_RST;
            cfg_reg.refresh_ticks  <= gsce_pkg::REFR_RST;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                gsce_pkg::REG_RATIO:  cfg_reg.ratio_limit    <= pwdata[gsce_pkg::LIMIT_W-1:0];
                gsce_pkg::REG_THRESH: cfg_reg.frag_threshold <= pwdata[gsce_pkg::NFRAG_W-1:0];
                gsce_pkg::REG_REFR:   cfg_reg.refresh_ticks  <= pwdata;
                default:              cfg_reg                <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            gsce_pkg::REG_RATIO:  prdata = 32'(cfg_reg.ratio_limit);
            gsce_pkg::REG_THRESH: prdata = 32'(cfg_reg.frag_threshold);
            gsce_pkg::REG_REFR:   prdata = cfg_reg.refresh_ticks;
            default:              prdata = '0;
        endcase
    end

    gsce_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    gsce_datapath #(
        .WINDOW_MAX  (WINDOW_MAX),
        .MIN_SAMPLES (MIN_SAMPLES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg       (cfg_reg),
        .req       (req),
        .rsp_ready (rsp_ready),
        .rsp_valid (rsp_valid),
        .rsp       (rsp),
        .stat      (stat)
    );

endmodule

// File: sv/gsce_window.sv
// Sliding sample window: circular sample store, head, fill count and running sum.
// Depends on gsce_pkg.
module gsce_window #(
    parameter int WINDOW_MAX = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 clr,
    input  logic                                 drop,
    input  logic                                 add,
    input  logic signed [gsce_pkg::SAMPLE_W-1:0] add_val,
    output logic [$clog2(WINDOW_MAX+1)-1:0]      count,
    output logic signed [gsce_pkg::SAMPLE_W+$clog2(WINDOW_MAX)-1:0] sum,
    output logic                                 full
);
    localparam int HEAD_W = $clog2(WINDOW_MAX);
    localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W  = gsce_pkg::SAMPLE_W + $clog2(WINDOW_MAX);

    logic signed [gsce_pkg::SAMPLE_W-1:0] mem [WINDOW_MAX];
    logic signed [gsce_pkg::SAMPLE_W-1:0] rd_reg;
    logic [HEAD_W-1:0] head_reg, head_next, head_inc, wr_idx;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W:0] pos;

    assign pos    = (CNT_W+1)'(head_reg) + (CNT_W+1)'(count_reg);
    assign wr_idx = (pos >= (CNT_W+1)'(WINDOW_MAX)) ?
                    HEAD_W'(pos - (CNT_W+1)'(WINDOW_MAX)) : HEAD_W'(pos);
    assign head_inc = (head_reg == HEAD_W'(WINDOW_MAX - 1)) ? '0 : head_reg + HEAD_W'(1);

    // read port follows the head; the oldest word is registered and ready in the cycle after head moves
    always_ff @(posedge clk)
    begin
        if (add)
        begin
            mem[wr_idx] <= add_val;
        end
        rd_reg <= mem[head_reg];
    end

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        if (clr)
        begin
            head_next  = '0;
            count_next = '0;
            sum_next   = '0;
        end
        else if (drop && count_reg != '0)
        begin
            head_next  = head_inc;
            count_next = count_reg - CNT_W'(1);
            sum_next   = sum_reg - SUM_W'(rd_reg);
        end
        else if (add)
        begin
            count_next = count_reg + CNT_W'(1);
            sum_next   = sum_reg + SUM_W'(add_val);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
        end
    end

    assign count = count_reg;
    assign sum   = sum_reg;
    assign full  = (count_reg == CNT_W'(WINDOW_MAX));

endmodule

// File: sv/gsce_muldiv.sv
// Serial signed multiply-then-divide: sign(x) * min(trunc(|x|*b/d), 2^60).
// Shift-add multiply, one bit a cycle, then restoring division. Depends on gsce_pkg.
module gsce_muldiv (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [gsce_pkg::X_W-1:0]   x,
    input  logic [gsce_pkg::B_W-1:0]          b,
    input  logic [gsce_pkg::D_W-1:0]          d,
    output logic                              done,
    output logic signed [gsce_pkg::RES_W-1:0] res
);
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_MUL  = 2'd1;
    localparam logic [1:0] PH_DIV  = 2'd2;
    localparam logic [1:0] PH_FIN  = 2'd3;
    localparam int P_W   = gsce_pkg::P_W;
    localparam int D_W   = gsce_pkg::D_W;
    localparam int MAG_W = gsce_pkg::MAG_W;
    localparam int RES_W = gsce_pkg::RES_W;
    localparam int CW    = gsce_pkg::MDCNT_W;
    localparam logic [P_W-1:0] CAP = P_W'(1) << gsce_pkg::CAP_BIT;

    logic [1:0] ph_reg, ph_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic done_reg, done_next;
    logic neg_reg, neg_next;
    logic [MAG_W-1:0] mag_reg, mag_next;
    logic [gsce_pkg::B_W-1:0] bsh_reg, bsh_next;
    logic [D_W-1:0] d_reg, d_next, rem_reg, rem_next;
    logic [P_W-1:0] acc_reg, acc_next, satq;
    logic signed [RES_W-1:0] res_reg, res_next;
    logic [gsce_pkg::X_W-1:0] xabs;
    logic [D_W:0] trial;
    logic ge;

    assign xabs  = x[gsce_pkg::X_W-1] ? (~x + 1'b1) : x;
    assign trial = {rem_reg, acc_reg[P_W-1]};
    assign ge    = trial >= {1'b0, d_reg};
    assign satq  = (acc_reg > CAP) ? CAP : acc_reg;

    always_comb
    begin
        ph_next   = ph_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        mag_next  = mag_reg;
        bsh_next  = bsh_reg;
        d_next    = d_reg;
        rem_next  = rem_reg;
        acc_next  = acc_reg;
        res_next  = res_reg;
        case (ph_reg)
            PH_IDLE:
            begin
                if (start)
                begin
                    neg_next = x[gsce_pkg::X_W-1];
                    mag_next = xabs[MAG_W-1:0];
                    bsh_next = b;
                    d_next   = d;
                    acc_next = '0;
                    cnt_next = '0;
                    ph_next  = PH_MUL;
                end
            end
            PH_MUL:
            begin
                acc_next = {acc_reg[P_W-2:0], 1'b0} +
                           (bsh_reg[gsce_pkg::B_W-1] ? P_W'(mag_reg) : '0);
                bsh_next = {bsh_reg[gsce_pkg::B_W-2:0], 1'b0};
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(gsce_pkg::B_W - 1))
                begin
                    cnt_next = '0;
                    rem_next = '0;
                    ph_next  = PH_DIV;
                end
            end
            PH_DIV:
            begin
                rem_next = ge ? D_W'(trial - {1'b0, d_reg}) : trial[D_W-1:0];
                acc_next = {acc_reg[P_W-2:0], ge};
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(P_W - 1))
                begin
                    ph_next = PH_FIN;
                end
            end
            PH_FIN:
            begin
                res_next  = neg_reg ? -$signed(satq[RES_W-1:0]) : $signed(satq[RES_W-1:0]);
                done_next = 1'b1;
                ph_next   = PH_IDLE;
            end
            default:
            begin
                ph_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg   <= PH_IDLE;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            ph_reg   <= ph_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        mag_reg <= mag_next;
        bsh_reg <= bsh_next;
        d_reg   <= d_next;
        rem_reg <= rem_next;
        acc_reg <= acc_next;
        res_reg <= res_next;
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

// File: sv/gsce_datapath.sv
// Datapath: item register, screen area, idle counter, both windows, the shared
// multiply-divide unit, model terms and the result register. Depends on gsce_pkg.
module gsce_datapath #(
    parameter int WINDOW_MAX  = 16,
    parameter int MIN_SAMPLES = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  gsce_pkg::dp_cmd_t  cmd,
    input  gsce_pkg::cfg_t     cfg,
    input  gsce_pkg::req_t     req,
    input  logic               rsp_ready,
    output logic               rsp_valid,
    output gsce_pkg::rsp_t     rsp,
    output gsce_pkg::dp_stat_t stat
);
    localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W  = gsce_pkg::SAMPLE_W + $clog2(WINDOW_MAX);
    localparam int RES_W  = gsce_pkg::RES_W;
    localparam int X_W    = gsce_pkg::X_W;
    localparam int AW     = gsce_pkg::AREA_W;
    localparam int LW     = gsce_pkg::LIMIT_W;
    localparam int PRD_W  = gsce_pkg::LIMIT_W + 1 + gsce_pkg::AREA_W;
    localparam int T_W    = gsce_pkg::TIME_W + 8;

    gsce_pkg::req_t item_reg;
    gsce_pkg::rsp_t rsp_reg, rsp_next;
    logic rsp_valid_reg, rsp_valid_next;
    logic [AW-1:0] scr_reg, scr_next;
    logic [gsce_pkg::TICK_W-1:0] idle_reg, idle_next;
    logic signed [RES_W-1:0] a_reg, g_reg, t1_reg;
    logic signed [RES_W:0] tb_reg, tf_reg, num_reg;

    logic [CNT_W-1:0] cnt_w, cnt_o;
    logic signed [SUM_W-1:0] sum_w, sum_o;
    logic full_w, full_o;
    logic w_clr, w_drop, w_add, o_drop, o_add;
    logic signed [gsce_pkg::SAMPLE_W-1:0] sample;

    logic md_done;
    logic signed [RES_W-1:0] md_res;
    logic signed [X_W-1:0] md_x;
    logic [gsce_pkg::B_W-1:0] md_b;
    logic [gsce_pkg::D_W-1:0] md_d;
    logic [T_W-1:0] t256;

    logic large_b, large_f, fraglike, ready_now, w_low, o_low, out_act;
    logic [PRD_W-1:0] lim_b, lim_f;

    assign t256 = {item_reg.grab_time, 8'b0};

    // floor(S/area) <= L is the same as S < (L+1)*area
    assign lim_b = PRD_W'({1'b0, cfg.ratio_limit} + (LW+1)'(1)) * PRD_W'(item_reg.bounds_area);
    assign lim_f = PRD_W'({1'b0, cfg.ratio_limit} + (LW+1)'(1)) * PRD_W'(item_reg.frag_area);
    assign large_b = (item_reg.bounds_area != '0) && (PRD_W'(scr_reg) < lim_b);
    assign large_f = (item_reg.frag_area != '0) && (PRD_W'(scr_reg) < lim_f);
    assign fraglike = item_reg.frag_count >= cfg.frag_threshold;
    assign w_low = 32'(cnt_w) < MIN_SAMPLES;
    assign o_low = 32'(cnt_o) < MIN_SAMPLES;
    assign ready_now = (scr_reg != '0) && !w_low && !o_low;

    always_comb
    begin
        md_x = '0;
        md_b = gsce_pkg::B_W'(1);
        md_d = gsce_pkg::D_W'(1);
        case (cmd.md_sel)
            gsce_pkg::MD_WSAMP:
            begin
                md_x = X_W'(t256);
                md_b = scr_reg;
                md_d = item_reg.bounds_area;
            end
            gsce_pkg::MD_AVG_W:
            begin
                md_x = X_W'(sum_w);
                md_d = gsce_pkg::D_W'(cnt_w);
            end
            gsce_pkg::MD_AVG_O:
            begin
                md_x = X_W'(sum_o);
                md_d = gsce_pkg::D_W'(cnt_o);
            end
            gsce_pkg::MD_AF:
            begin
                md_x = X_W'(a_reg);
                md_b = item_reg.frag_area;
                md_d = scr_reg;
            end
            gsce_pkg::MD_AB:
            begin
                md_x = X_W'(a_reg);
                md_b = item_reg.bounds_area;
                md_d = scr_reg;
            end
            gsce_pkg::MD_GN:
            begin
                md_x = X_W'(g_reg);
                md_b = gsce_pkg::B_W'(item_reg.frag_count);
            end
            gsce_pkg::MD_NUMN:
            begin
                md_x = X_W'(num_reg);
                md_d = gsce_pkg::D_W'(item_reg.frag_count);
            end
            default:
            begin
                md_x = '0;
            end
        endcase
    end

    gsce_muldiv u_md (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.md_start),
        .x     (md_x),
        .b     (md_b),
        .d     (md_d),
        .done  (md_done),
        .res   (md_res)
    );

    // clamp to the 48-bit signed sample range
    always_comb
    begin
        if (md_res[RES_W-1:gsce_pkg::SAMPLE_W-1] == {(RES_W-gsce_pkg::SAMPLE_W+1){md_res[RES_W-1]}})
        begin
            sample = md_res[gsce_pkg::SAMPLE_W-1:0];
        end
        else if (md_res[RES_W-1])
        begin
            sample = {1'b1, {(gsce_pkg::SAMPLE_W-1){1'b0}}};
        end
        else
        begin
            sample = {1'b0, {(gsce_pkg::SAMPLE_W-1){1'b1}}};
        end
    end

    assign w_clr  = (cmd.act == gsce_pkg::ACT_SCREEN) && (item_reg.screen_area != scr_reg);
    assign w_drop = (cmd.act == gsce_pkg::ACT_DROP_W) || (cmd.act == gsce_pkg::ACT_REFRESH);
    assign o_drop = (cmd.act == gsce_pkg::ACT_DROP_O) || (cmd.act == gsce_pkg::ACT_REFRESH);
    assign w_add  = cmd.act == gsce_pkg::ACT_ADD_W;
    assign o_add  = cmd.act == gsce_pkg::ACT_ADD_O;

    gsce_window #(.WINDOW_MAX(WINDOW_MAX)) u_whole (
        .clk     (clk),
        .rst_n   (rst_n),
        .clr     (w_clr),
        .drop    (w_drop),
        .add     (w_add),
        .add_val (sample),
        .count   (cnt_w),
        .sum     (sum_w),
        .full    (full_w)
    );

    gsce_window #(.WINDOW_MAX(WINDOW_MAX)) u_over (
        .clk     (clk),
        .rst_n   (rst_n),
        .clr     (w_clr),
        .drop    (o_drop),
        .add     (o_add),
        .add_val (sample),
        .count   (cnt_o),
        .sum     (sum_o),
        .full    (full_o)
    );

    assign out_act = (cmd.act == gsce_pkg::ACT_OUT_MODEL) || (cmd.act == gsce_pkg::ACT_OUT_HEUR) ||
                     (cmd.act == gsce_pkg::ACT_OUT_EMPTY);

    always_comb
    begin
        scr_next       = scr_reg;
        idle_next      = idle_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        case (cmd.act)
            gsce_pkg::ACT_TICK:
            begin
                if (idle_reg != '1)
                begin
                    idle_next = idle_reg + gsce_pkg::TICK_W'(1);
                end
            end
            gsce_pkg::ACT_SCREEN:
            begin
                scr_next = item_reg.screen_area;
            end
            gsce_pkg::ACT_REFRESH, gsce_pkg::ACT_ADD_W, gsce_pkg::ACT_ADD_O:
            begin
                idle_next = '0;
            end
            gsce_pkg::ACT_OUT_MODEL:
            begin
                rsp_next.choice     = (tb_reg <= tf_reg) ? gsce_pkg::CHOICE_BOUNDS
                                                         : gsce_pkg::CHOICE_FRAGS;
                rsp_next.used_model = 1'b1;
            end
            gsce_pkg::ACT_OUT_HEUR:
            begin
                rsp_next.used_model = 1'b0;
                if (large_b && w_low)
                begin
                    rsp_next.choice = gsce_pkg::CHOICE_BOUNDS;
                end
                else if (fraglike && o_low)
                begin
                    rsp_next.choice = gsce_pkg::CHOICE_FRAGS;
                end
                else if (large_f)
                begin
                    rsp_next.choice = gsce_pkg::CHOICE_BOUNDS;
                end
                else
                begin
                    rsp_next.choice = gsce_pkg::CHOICE_FRAGS;
                end
            end
            gsce_pkg::ACT_OUT_EMPTY:
            begin
                rsp_next.choice     = gsce_pkg::CHOICE_NONE;
                rsp_next.used_model = 1'b0;
            end
            default:
            begin
                scr_next = scr_reg;
            end
        endcase
        if (out_act)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scr_reg       <= '0;
            idle_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            scr_reg       <= scr_next;
            idle_reg      <= idle_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (cmd.act == gsce_pkg::ACT_LOAD)
        begin
            item_reg <= req;
        end
        if (cmd.act == gsce_pkg::ACT_SAVE_A)
        begin
            a_reg <= md_res;
        end
        if (cmd.act == gsce_pkg::ACT_SAVE_G)
        begin
            g_reg <= md_res;
        end
        if (cmd.act == gsce_pkg::ACT_SAVE_T1)
        begin
            t1_reg <= md_res;
        end
        if (cmd.act == gsce_pkg::ACT_SAVE_TB)
        begin
            tb_reg <= (RES_W+1)'(md_res) + (RES_W+1)'(g_reg);
        end
        if (cmd.act == gsce_pkg::ACT_SAVE_TF)
        begin
            tf_reg <= (RES_W+1)'(t1_reg) + (RES_W+1)'(md_res);
        end
        if (cmd.act == gsce_pkg::ACT_SAVE_NUM)
        begin
            num_reg <= $signed((RES_W+1)'(t256)) - (RES_W+1)'(md_res);
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign stat.op          = item_reg.op;
    assign stat.rep_w_ok    = item_reg.time_valid && (scr_reg != '0) && large_b;
    assign stat.rep_o_ok    = item_reg.time_valid && (item_reg.frag_count != '0) && fraglike &&
                              (cnt_w != '0) && (scr_reg != '0);
    assign stat.empty_req   = (item_reg.frag_count == '0) || (item_reg.bounds_area == '0);
    assign stat.refresh_due = (idle_reg >= cfg.refresh_ticks) && ready_now;
    assign stat.model_ready = ready_now;
    assign stat.whole_full  = full_w;
    assign stat.over_full   = full_o;
    assign stat.md_done     = md_done;
    assign stat.out_full    = rsp_valid_reg && !rsp_ready;

endmodule

// File: sv/gsce_ctrl.sv
// Controller: sequences the datapath actions and multiply-divide runs of each word.
// Depends on gsce_pkg.
module gsce_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  gsce_pkg::dp_stat_t stat,
    output gsce_pkg::dp_cmd_t  cmd
);
    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_DISP    = 5'd1;
    localparam logic [4:0] S_W_MD    = 5'd2;
    localparam logic [4:0] S_W_DROP  = 5'd3;
    localparam logic [4:0] S_W_ADD   = 5'd4;
    localparam logic [4:0] S_O_AVG   = 5'd5;
    localparam logic [4:0] S_O_AF_ST = 5'd6;
    localparam logic [4:0] S_O_AF    = 5'd7;
    localparam logic [4:0] S_O_N_ST  = 5'd8;
    localparam logic [4:0] S_O_N     = 5'd9;
    localparam logic [4:0] S_O_DROP  = 5'd10;
    localparam logic [4:0] S_O_ADD   = 5'd11;
    localparam logic [4:0] S_REFR    = 5'd12;
    localparam logic [4:0] S_SEL     = 5'd13;
    localparam logic [4:0] S_D_AW    = 5'd14;
    localparam logic [4:0] S_D_AO_ST = 5'd15;
    localparam logic [4:0] S_D_AO    = 5'd16;
    localparam logic [4:0] S_D_AB_ST = 5'd17;
    localparam logic [4:0] S_D_AB    = 5'd18;
    localparam logic [4:0] S_D_AF_ST = 5'd19;
    localparam logic [4:0] S_D_AF    = 5'd20;
    localparam logic [4:0] S_D_GN_ST = 5'd21;
    localparam logic [4:0] S_D_GN    = 5'd22;
    localparam logic [4:0] S_OUT_MOD = 5'd23;
    localparam logic [4:0] S_OUT_HEU = 5'd24;
    localparam logic [4:0] S_OUT_EMP = 5'd25;

    logic [4:0] state_reg, state_next;

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        cmd.act      = gsce_pkg::ACT_NONE;
        cmd.md_start = 1'b0;
        cmd.md_sel   = gsce_pkg::MD_WSAMP;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.act    = gsce_pkg::ACT_LOAD;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                case (stat.op)
                    gsce_pkg::OP_TICK:
                    begin
                        cmd.act    = gsce_pkg::ACT_TICK;
                        state_next = S_IDLE;
                    end
                    gsce_pkg::OP_WHOLE:
                    begin
                        if (stat.rep_w_ok)
                        begin
                            cmd.md_start = 1'b1;
                            cmd.md_sel   = gsce_pkg::MD_WSAMP;
                            state_next   = S_W_MD;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    gsce_pkg::OP_FRAG:
                    begin
                        if (stat.rep_o_ok)
                        begin
                            cmd.md_start = 1'b1;
                            cmd.md_sel   = gsce_pkg::MD_AVG_W;
                            state_next   = S_O_AVG;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    default:
                    begin
                        if (stat.empty_req)
                        begin
                            state_next = S_OUT_EMP;
                        end
                        else
                        begin
                            cmd.act    = gsce_pkg::ACT_SCREEN;
                            state_next = S_REFR;
                        end
                    end
                endcase
            end
            S_W_MD:
            begin
                if (stat.md_done)
                begin
                    state_next = S_W_DROP;
                end
            end
            S_W_DROP:
            begin
                if (stat.whole_full)
                begin
                    cmd.act = gsce_pkg::ACT_DROP_W;
                end
                state_next = S_W_ADD;
            end
            S_W_ADD:
            begin
                cmd.act    = gsce_pkg::ACT_ADD_W;
                state_next = S_IDLE;
            end
            S_O_AVG:
            begin
                if (stat.md_done)
                begin
                    cmd.act    = gsce_pkg::ACT_SAVE_A;
                    state_next = S_O_AF_ST;
                end
            end
            S_O_AF_ST:
            begin
                cmd.md_start = 1'b1;
                cmd.md_sel   = gsce_pkg::MD_AF;
                state_next   = S_O_AF;
            end
            S_O_AF:
            begin
                if (stat.md_done)
                begin
                    cmd.act    = gsce_pkg::ACT_SAVE_NUM;
                    state_next = S_O_N_ST;
                end
            end
            S_O_N_ST:
            begin
                cmd.md_start = 1'b1;
                cmd.md_sel   = gsce_pkg::MD_NUMN;
                state_next   = S_O_N;
            end
            S_O_N:
            begin
                if (stat.md_done)
                begin
                    state_next = S_O_DROP;
                end
            end
            S_O_DROP:
            begin
                if (stat.over_full)
                begin
                    cmd.act = gsce_pkg::ACT_DROP_O;
                end
                state_next = S_O_ADD;
            end
            S_O_ADD:
            begin
                cmd.act    = gsce_pkg::ACT_ADD_O;
                state_next = S_IDLE;
            end
            S_REFR:
            begin
                if (stat.refresh_due)
                begin
                    cmd.act = gsce_pkg::ACT_REFRESH;
                end
                state_next = S_SEL;
            end
            S_SEL:
            begin
                if (stat.model_ready)
                begin
                    cmd.md_start = 1'b1;
                    cmd.md_sel   = gsce_pkg::MD_AVG_W;
                    state_next   = S_D_AW;
                end
                else
                begin
                    state_next = S_OUT_HEU;
                end
            end
            S_D_AW:
            begin
                if (stat.md_done)
                begin
                    cmd.act    = gsce_pkg::ACT_SAVE_A;
                    state_next = S_D_AO_ST;
                end
            end
            S_D_AO_ST:
            begin
                cmd.md_start = 1'b1;
                cmd.md_sel   = gsce_pkg::MD_AVG_O;
                state_next   = S_D_AO;
            end
            S_D_AO:
            begin
                if (stat.md_done)
                begin
                    cmd.act    = gsce_pkg::ACT_SAVE_G;
                    state_next = S_D_AB_ST;
                end
            end
            S_D_AB_ST:
            begin
                cmd.md_start = 1'b1;
                cmd.md_sel   = gsce_pkg::MD_AB;
                state_next   = S_D_AB;
            end
            S_D_AB:
            begin
                if (stat.md_done)
                begin
                    cmd.act    = gsce_pkg::ACT_SAVE_TB;
                    state_next = S_D_AF_ST;
                end
            end
            S_D_AF_ST:
            begin
                cmd.md_start = 1'b1;
                cmd.md_sel   = gsce_pkg::MD_AF;
                state_next   = S_D_AF;
            end
            S_D_AF:
            begin
                if (stat.md_done)
                begin
                    cmd.act    = gsce_pkg::ACT_SAVE_T1;
                    state_next = S_D_GN_ST;
                end
            end
            S_D_GN_ST:
            begin
                cmd.md_start = 1'b1;
                cmd.md_sel   = gsce_pkg::MD_GN;
                state_next   = S_D_GN;
            end
            S_D_GN:
            begin
                if (stat.md_done)
                begin
                    cmd.act    = gsce_pkg::ACT_SAVE_TF;
                    state_next = S_OUT_MOD;
                end
            end
            S_OUT_MOD:
            begin
                if (!stat.out_full)
                begin
                    cmd.act    = gsce_pkg::ACT_OUT_MODEL;
                    state_next = S_IDLE;
                end
            end
            S_OUT_HEU:
            begin
                if (!stat.out_full)
                begin
                    cmd.act    = gsce_pkg::ACT_OUT_HEUR;
                    state_next = S_IDLE;
                end
            end
            S_OUT_EMP:
            begin
                if (!stat.out_full)
                begin
                    cmd.act    = gsce_pkg::ACT_OUT_EMPTY;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: tb/grab_strategy_cost_estimator_core_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for grab_strategy_cost_estimator_core: random capture sessions,
// an own estimator of the window/cost logic and an ordered compare of every decision.
// Depends on gsce_pkg and the core RTL.
module grab_strategy_cost_estimator_core_tb;

    localparam int WIN = 16;
    localparam int MINS = 4;
    localparam int AREA_MAX = 67108864;
    localparam int DRAIN_CYCLES = 700;

    logic            clk = 0;
    logic            rst_n = 0;
    logic            req_valid = 0;
    logic            req_ready;
    gsce_pkg::req_t  req_word = '0;
    logic            rsp_valid;
    logic            rsp_ready = 0;
    gsce_pkg::rsp_t  rsp_word;
    logic            psel = 0;
    logic            penable = 0;
    logic            pwrite = 0;
    logic [3:0]      paddr = '0;
    logic [31:0]     pwdata = '0;
    logic [31:0]     prdata;
    logic            pready;

    grab_strategy_cost_estimator_core dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req_word),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp_word),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #2 clk = ~clk;

    // estimator state: index 0 whole-screen window, 1 per-fragment overhead window
    longint      win_samp [2][WIN];
    int          win_head [2];
    int          win_cnt  [2];
    longint      win_sum  [2];
    longint unsigned known_area;
    logic [31:0] idle_cnt;
    logic [7:0]  ratio_lim;
    logic [15:0] frag_thr;
    logic [31:0] refresh_lim;

    gsce_pkg::req_t pending [$];
    gsce_pkg::rsp_t awaited [$];
    int   errors = 0;
    bit   calm = 0;
    int   holds_asked = 0;
    int   holds_done = 0;
    int   send_gap = 0;
    int   stall_left = 0;
    int   hold_left = 0;

    function automatic void queue_req(gsce_pkg::req_t r);
        pending.insert(pending.size(), r);
    endfunction

    function automatic longint scale_div(longint a, longint unsigned b, longint unsigned d);
        longint unsigned mag, q, r, res, cap;
        cap = 64'd1 << 60;
        mag = (a < 0) ? longint'(-a) : a;
        q = mag / d;
        r = mag % d;
        if (q != 0 && b > cap / q)
            res = cap;
        else
        begin
            res = q * b + (r * b) / d;
            if (res > cap)
                res = cap;
        end
        return (a < 0) ? -longint'(res) : longint'(res);
    endfunction

    function automatic longint clamp48(longint v);
        longint hi;
        hi = (longint'(1) <<< 47) - 1;
        if (v > hi)
            return hi;
        if (v < -hi - 1)
            return -hi - 1;
        return v;
    endfunction

    function automatic longint win_mean(int w);
        if (win_cnt[w] == 0)
            return 0;
        return win_sum[w] / longint'(win_cnt[w]);
    endfunction

    function automatic void win_drop(int w);
        if (win_cnt[w] == 0)
            return;
        win_sum[w] -= win_samp[w][win_head[w]];
        win_head[w] = (win_head[w] + 1) % WIN;
        win_cnt[w]--;
    endfunction

    function automatic void win_push(int w, longint v);
        if (win_cnt[w] >= WIN)
            win_drop(w);
        win_samp[w][(win_head[w] + win_cnt[w]) % WIN] = v;
        win_cnt[w]++;
        win_sum[w] += v;
        idle_cnt = '0;
    endfunction

    function automatic bit area_large(longint unsigned area);
        return area >= 1 && known_area / area <= 64'(ratio_lim);
    endfunction

    function automatic bit model_on();
        return known_area != 0 && win_cnt[0] >= MINS && win_cnt[1] >= MINS;
    endfunction

    function automatic void estimator_reset();
        ratio_lim = gsce_pkg::RATIO_RST;
        frag_thr = gsce_pkg::THRESH_RST;
        refresh_lim = gsce_pkg::REFR_RST;
        for (int w = 0; w < 2; w++)
        begin
            win_head[w] = 0;
            win_cnt[w] = 0;
            win_sum[w] = 0;
        end
        known_area = 0;
        idle_cnt = '0;
    endfunction

    // applies one accepted word and queues the decision it produces, if any
    function automatic void estimate(gsce_pkg::req_t r);
        longint unsigned bnd, frg, n, s;
        longint t8, a, g, tb, tf, num;
        gsce_pkg::rsp_t o;
        bnd = 64'(r.bounds_area);
        frg = 64'(r.frag_area);
        n = 64'(r.frag_count);
        s = known_area;
        t8 = longint'({r.grab_time, 8'd0});
        o = '0;
        case (r.op)
            gsce_pkg::OP_TICK:
                if (idle_cnt != 32'hFFFF_FFFF)
                    idle_cnt++;
            gsce_pkg::OP_WHOLE:
                if (r.time_valid && s != 0 && area_large(bnd))
                    win_push(0, clamp48(scale_div(t8, s, bnd)));
            gsce_pkg::OP_FRAG:
                if (r.time_valid && n >= 1 && n >= 64'(frag_thr) && win_cnt[0] > 0 && s != 0)
                begin
                    num = t8 - scale_div(win_mean(0), frg, s);
                    win_push(1, clamp48(num / longint'(n)));
                end
            default:
            begin
                if (n != 0 && bnd != 0)
                begin
                    if (known_area != 64'(r.screen_area))
                    begin
                        known_area = 64'(r.screen_area);
                        for (int w = 0; w < 2; w++)
                        begin
                            win_head[w] = 0;
                            win_cnt[w] = 0;
                            win_sum[w] = 0;
                        end
                    end
                    s = known_area;
                    if (idle_cnt >= refresh_lim && model_on())
                    begin
                        win_drop(0);
                        win_drop(1);
                        idle_cnt = '0;
                    end
                    if (model_on())
                    begin
                        a = win_mean(0);
                        g = win_mean(1);
                        tb = scale_div(a, bnd, s) + g;
                        tf = scale_div(a, frg, s) + scale_div(g, n, 1);
                        o.choice = (tb <= tf) ? gsce_pkg::CHOICE_BOUNDS : gsce_pkg::CHOICE_FRAGS;
                        o.used_model = 1'b1;
                    end
                    else if (area_large(bnd) && win_cnt[0] < MINS)
                        o.choice = gsce_pkg::CHOICE_BOUNDS;
                    else if (n >= 64'(frag_thr) && win_cnt[1] < MINS)
                        o.choice = gsce_pkg::CHOICE_FRAGS;
                    else if (area_large(frg))
                        o.choice = gsce_pkg::CHOICE_BOUNDS;
                    else
                        o.choice = gsce_pkg::CHOICE_FRAGS;
                end
                awaited.insert(awaited.size(), o);
            end
        endcase
    endfunction

    // driver: one word offered at a time, random gaps between words
    always @(posedge clk or negedge rst_n)
    begin
        logic nv;
        if (!rst_n)
            req_valid <= 1'b0;
        else
        begin
            nv = req_valid;
            if (req_valid && req_ready)
            begin
                estimate(req_word);
                nv = 1'b0;
            end
            if (!nv)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (pending.size() > 0)
                begin
                    req_word <= pending.pop_front();
                    nv = 1'b1;
                    if (!calm && $urandom_range(0, 9) == 0)
                        send_gap = $urandom_range(1, 11);
                end
            end
            req_valid <= nv;
        end
    end

    // monitor: random stalls, one long hold-off on request, ordered compare
    always @(posedge clk or negedge rst_n)
    begin
        gsce_pkg::rsp_t e;
        if (!rst_n)
            rsp_ready <= 1'b0;
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (awaited.size() == 0)
                begin
                    $error("decision with none pending: choice %0d used_model %0d",
                           rsp_word.choice, rsp_word.used_model);
                    errors++;
                end
                else
                begin
                    e = awaited.pop_front();
                    if (rsp_word.choice !== e.choice)
                    begin
                        $error("choice: expected %0d, got %0d", e.choice, rsp_word.choice);
                        errors++;
                    end
                    if (rsp_word.used_model !== e.used_model)
                    begin
                        $error("used_model: expected %0d, got %0d",
                               e.used_model, rsp_word.used_model);
                        errors++;
                    end
                end
            end
            if (holds_done != holds_asked)
            begin
                holds_done = holds_asked;
                hold_left = 3000;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_ready <= 1'b0;
            end
            else
            begin
                rsp_ready <= 1'b1;
                if (!calm && $urandom_range(0, 11) == 0)
                    stall_left = $urandom_range(1, 11);
            end
        end
    end

    function automatic gsce_pkg::req_t mk(logic [1:0] op, int scr, int bnd, int frg, int n,
                                          logic [39:0] t, bit v);
        gsce_pkg::req_t r;
        r.op = op;
        r.screen_area = 27'(scr);
        r.bounds_area = 27'(bnd);
        r.frag_area = 27'(frg);
        r.frag_count = 16'(n);
        r.grab_time = t;
        r.time_valid = v;
        return r;
    endfunction

    function automatic logic [39:0] rand_time();
        if ($urandom_range(0, 5) == 0)
            return {8'($urandom), 32'($urandom)};
        return 40'($urandom_range(0, 200000));
    endfunction

    function automatic gsce_pkg::req_t noise();
        return mk(2'($urandom), $urandom_range(0, AREA_MAX), $urandom_range(0, AREA_MAX),
                  $urandom_range(0, AREA_MAX), $urandom_range(0, 65535),
                  {8'($urandom), 32'($urandom)}, 1'($urandom));
    endfunction

    // a well-formed capture session on one screen size, with some noise mixed in
    task automatic add_session();
        int scr, bnd, n, lo, hi, len, k;
        k = $urandom_range(0, 7);
        if (k == 0)
            scr = 0;
        else if (k == 1)
            scr = AREA_MAX;
        else if (k == 2)
            scr = $urandom_range(1, AREA_MAX);
        else
            scr = $urandom_range(1, 5000);
        queue_req(mk(gsce_pkg::OP_DECIDE, scr, $urandom_range(1, scr > 0 ? scr : 1),
                     $urandom_range(0, scr), $urandom_range(1, 40), rand_time(), 1));
        len = $urandom_range(10, 30);
        for (int i = 0; i < len; i++)
        begin
            k = $urandom_range(0, 29);
            if (k < 10)
            begin
                if (ratio_lim == 0)
                    bnd = (scr < AREA_MAX) ? $urandom_range(scr + 1, AREA_MAX) : scr;
                else
                begin
                    lo = scr / (ratio_lim + 1) + 1;
                    bnd = $urandom_range(lo > scr ? scr : lo, scr > 0 ? scr : 1);
                end
                queue_req(mk(gsce_pkg::OP_WHOLE, $urandom_range(0, AREA_MAX), bnd,
                             $urandom_range(0, scr), $urandom_range(0, 65535),
                             rand_time(), $urandom_range(0, 9) != 0));
            end
            else if (k < 18)
            begin
                hi = (frag_thr > 65485) ? 65535 : frag_thr + 50;
                n = $urandom_range(frag_thr, hi);
                if (n == 0)
                    n = 1;
                queue_req(mk(gsce_pkg::OP_FRAG, $urandom_range(0, AREA_MAX),
                             $urandom_range(0, AREA_MAX), $urandom_range(0, scr),
                             n, rand_time(), $urandom_range(0, 9) != 0));
            end
            else if (k < 21)
                queue_req(mk(gsce_pkg::OP_TICK, $urandom_range(0, AREA_MAX),
                             $urandom_range(0, AREA_MAX), $urandom_range(0, AREA_MAX),
                             $urandom_range(0, 65535), rand_time(), 1'($urandom)));
            else if (k < 29)
                queue_req(mk(gsce_pkg::OP_DECIDE, scr, $urandom_range(0, scr > 0 ? scr : 1),
                             $urandom_range(0, scr),
                             ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 60),
                             rand_time(), 1'($urandom)));
            else
                queue_req(noise());
        end
    endtask

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            gsce_pkg::REG_RATIO:  ratio_lim = val[7:0];
            gsce_pkg::REG_THRESH: frag_thr = val[15:0];
            default:              refresh_lim = val;
        endcase
    endtask

    task automatic wait_idle();
        while (pending.size() > 0 || req_valid || awaited.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    logic [7:0]  ph_ratio  [6] = '{8'd9, 8'd0, 8'd255, 8'd3, 8'd20, 8'd9};
    logic [15:0] ph_thresh [6] = '{16'd10, 16'd1, 16'd65535, 16'd2, 16'd5, 16'd10};
    logic [31:0] ph_refr   [6] = '{32'd1800000, 32'd1, 32'hFFFF_FFFF, 32'd2, 32'd3, 32'd5};

    initial
    begin
        estimator_reset();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        // directed: empty requests, zero screen, extremes, ignored reports
        queue_req(mk(gsce_pkg::OP_DECIDE, 1000, 500, 100, 0, '0, 1));
        queue_req(mk(gsce_pkg::OP_DECIDE, 1000, 0, 100, 5, '0, 1));
        queue_req(mk(gsce_pkg::OP_WHOLE, 0, 100, 0, 1, 40'd500, 1));
        queue_req(mk(gsce_pkg::OP_DECIDE, 0, 100, 50, 20, '0, 1));
        queue_req(mk(gsce_pkg::OP_DECIDE, 0, 100, 50, 2, '0, 1));
        queue_req(mk(gsce_pkg::OP_DECIDE, AREA_MAX, AREA_MAX, AREA_MAX, 65535, '1, 1));
        queue_req(mk(gsce_pkg::OP_WHOLE, 0, AREA_MAX, 0, 0, '1, 0));
        queue_req(mk(gsce_pkg::OP_WHOLE, 0, AREA_MAX, 0, 0, '1, 1));
        queue_req(mk(gsce_pkg::OP_WHOLE, 0, 1, 0, 0, 40'd7, 1));
        for (int i = 0; i < 4; i++)
            queue_req(mk(gsce_pkg::OP_WHOLE, 0, AREA_MAX / 2, 0, 0, 40'd1000 + 40'(i), 1));
        queue_req(mk(gsce_pkg::OP_FRAG, 0, 0, AREA_MAX, 65535, '1, 1));
        queue_req(mk(gsce_pkg::OP_FRAG, 0, 0, 0, 9, 40'd100, 1));
        queue_req(mk(gsce_pkg::OP_FRAG, 0, 0, 1000, 12, 40'd100, 0));
        for (int i = 0; i < 4; i++)
            queue_req(mk(gsce_pkg::OP_FRAG, 0, 0, 5000, 10 + i, 40'd3000, 1));
        queue_req(mk(gsce_pkg::OP_TICK, 0, 0, 0, 0, '0, 0));
        queue_req(mk(gsce_pkg::OP_DECIDE, AREA_MAX, AREA_MAX, 1, 1, '0, 0));
        queue_req(mk(gsce_pkg::OP_DECIDE, AREA_MAX, 1, AREA_MAX, 65535, '0, 0));
        queue_req(mk(gsce_pkg::OP_DECIDE, 5000, 100, 0, 3, '0, 1));
        for (int p = 0; p < 6; p++)
        begin
            if (p > 0)
            begin
                wait_idle();
                reg_write(gsce_pkg::REG_RATIO, 32'(ph_ratio[p]));
                reg_write(gsce_pkg::REG_THRESH, 32'(ph_thresh[p]));
                reg_write(gsce_pkg::REG_REFR, ph_refr[p]);
            end
            if (p == 5)
                calm = 1;
            while (pending.size() < 255)
                add_session();
            if (p == 1)
                holds_asked++;
        end
        wait_idle();
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule
